@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file fmt_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

@@ hdl/fmt_pkg.sv @@
// package for the truncating single-precision multiplier
// constants and stage types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fmt_pkg;
    localparam int FRAC_W = 23;
    localparam int EXP_W = 8;
    localparam int MANT_W = 24;
    localparam int PROD_W = 48;
    localparam int SUM_W = 10;
    localparam logic [SUM_W-1:0] DENORM_LIMIT = 10'd128;
    localparam logic [SUM_W-1:0] INF_LIMIT = 10'd381;
    localparam logic [SUM_W-1:0] EXP_BIAS = 10'd127;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hff;

    typedef struct packed {
        logic                 sign;
        logic                 zero;
        logic [SUM_W-1:0]     sum;
        logic [MANT_W-1:0]    ma;
        logic [MANT_W-1:0]    mb;
    } unpack_t;

    typedef struct packed {
        logic                 sign;
        logic                 zero;
        logic [SUM_W-1:0]     sum;
        logic [PROD_W-1:0]    prod;
    } mult_t;

    typedef struct packed {
        logic                 sign;
        logic                 zero;
        logic [SUM_W-1:0]     expo;
        logic [FRAC_W-1:0]    frac;
    } norm_t;
endpackage
`default_nettype wire

@@ hdl/float_multiply_truncating.sv @@
// accepts one request per cycle while in_stall is low
// stages: unpack, 24x24 multiply, normalize, pack into the output register
// a stall freezes the whole pipeline only when the output holds a result
// and bubbles ahead of it are squeezed out
// asynchronous active-low reset clears all valid bits; payload is not reset
`timescale 1ns / 1ps
`default_nettype none
module float_multiply_truncating (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      product
);
    import fmt_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    unpack_t s1_reg, s1_next;
    mult_t   s2_reg, s2_next;
    norm_t   s3_reg, s3_next;
    logic [31:0] product_reg, product_next;

    logic [EXP_W-1:0] ea, eb;
    logic [FRAC_W-1:0] fa, fb;
    logic [SUM_W-1:0] res_e_w, sh;
    logic [MANT_W-1:0] den;
    logic [EXP_W-1:0] res_e;
    logic [FRAC_W-1:0] res_m;

    assign en4 = !(v4_reg && out_stall);
    assign en3 = en4 || !v3_reg;
    assign en2 = en3 || !v2_reg;
    assign en1 = en2 || !v1_reg;
    assign in_stall = !en1;

    // unpack
    always_comb
    begin
        ea = operand_a[30:23];
        eb = operand_b[30:23];
        fa = operand_a[22:0];
        fb = operand_b[22:0];
        s1_next.sign = operand_a[31] ^ operand_b[31];
        s1_next.zero = (ea == '0) || ((eb == '0) && (fb[22:21] == 2'b00));
        s1_next.ma = {(ea != '0), fa};
        s1_next.mb = {(eb != '0), fb};
        s1_next.sum = SUM_W'((ea == '0) ? 8'd1 : ea) + SUM_W'((eb == '0) ? 8'd1 : eb);
    end

    // multiply
    always_comb
    begin
        s2_next.sign = s1_reg.sign;
        s2_next.zero = s1_reg.zero;
        s2_next.sum = s1_reg.sum;
        s2_next.prod = PROD_W'(s1_reg.ma) * PROD_W'(s1_reg.mb);
    end

    // normalize
    always_comb
    begin
        s3_next.sign = s2_reg.sign;
        s3_next.zero = s2_reg.zero;
        if (s2_reg.prod[47])
        begin
            s3_next.frac = s2_reg.prod[46:24];
            s3_next.expo = s2_reg.sum + 10'd1;
        end
        else if (s2_reg.prod[46])
        begin
            s3_next.frac = s2_reg.prod[45:23];
            s3_next.expo = s2_reg.sum;
        end
        else if (s2_reg.prod[45])
        begin
            s3_next.frac = s2_reg.prod[44:22];
            s3_next.expo = s2_reg.sum - 10'd1;
        end
        else if (s2_reg.prod[44])
        begin
            s3_next.frac = s2_reg.prod[43:21];
            s3_next.expo = s2_reg.sum - 10'd2;
        end
        else
        begin
            s3_next.frac = '0;
            s3_next.expo = '0;
        end
    end

    // pack
    always_comb
    begin
        sh = DENORM_LIMIT - s3_reg.expo;
        den = {1'b1, s3_reg.frac} >> sh[4:0];
        res_e_w = s3_reg.expo - EXP_BIAS;
        if (s3_reg.zero)
        begin
            res_e = '0;
            res_m = '0;
        end
        else if (s3_reg.expo < DENORM_LIMIT)
        begin
            res_e = '0;
            res_m = (sh >= 10'd24) ? '0 : den[FRAC_W-1:0];
        end
        else if (s3_reg.expo > INF_LIMIT)
        begin
            res_e = EXP_ALL_ONES;
            res_m = '0;
        end
        else
        begin
            res_e = res_e_w[EXP_W-1:0];
            res_m = s3_reg.frac;
        end
        product_next = {s3_reg.sign, res_e, res_m};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en4) product_reg <= product_next;
    end

    assign out_valid = v4_reg;
    assign product = product_reg;
endmodule
`default_nettype wire

@@ hdl/fmt_checker.sv @@
// port-level checker for the truncating multiplier, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fmt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] product
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(product), "result dropped while stalled")
    `ASSERT_CLK(a_no_stall_idle, clk, rst_n, !out_valid |-> !in_stall,
                "input stalled with empty output")
    `ASSERT_CLK(a_known, clk, rst_n, in_valid |-> !$isunknown({in_stall, out_valid}),
                "unknown handshake while request offered")
    `ASSERT_CLK(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall),
                "input stalled without output stall")
endmodule

bind float_multiply_truncating fmt_checker u_fmt_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .product(product)
);
`default_nettype wire

@@ test/tb_float_multiply_truncating.sv @@
// testbench for the truncating single-precision multiplier
// drives operand pairs, predicts each product, checks results in order
// depends on float_multiply_truncating and fmt_pkg
`timescale 1ns / 1ps
module tb_float_multiply_truncating;
    import fmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] product;

    logic [31:0] expected_products[$];
    int          mismatch_count;
    int          checked_count;
    int          sent_count;
    int          idle_cycles;
    bit          timed_out;
    bit          stall_enable;

    float_multiply_truncating dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .product(product)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic logic [31:0] truncated_product(logic [31:0] a, logic [31:0] b);
        logic [EXP_W-1:0]  ea;
        logic [EXP_W-1:0]  eb;
        logic [FRAC_W-1:0] fa;
        logic [FRAC_W-1:0] fb;
        logic [MANT_W-1:0] ma;
        logic [MANT_W-1:0] mb;
        logic [PROD_W-1:0] full;
        logic [SUM_W-1:0]  expo;
        logic [FRAC_W-1:0] frac;
        logic [EXP_W-1:0]  res_e;
        logic [FRAC_W-1:0] res_m;
        logic [MANT_W-1:0] shifted;
        int                shift;
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        ma = (ea == 0) ? {1'b0, fa} : {1'b1, fa};
        mb = (eb == 0) ? {1'b0, fb} : {1'b1, fb};
        expo = SUM_W'((ea == 0) ? 1 : ea) + SUM_W'((eb == 0) ? 1 : eb);
        full = PROD_W'(ma) * PROD_W'(mb);
        if (full[47])
        begin
            frac = full[46:24];
            expo = expo + 10'd1;
        end
        else if (full[46])
            frac = full[45:23];
        else if (full[45])
        begin
            frac = full[44:22];
            expo = expo - 10'd1;
        end
        else if (full[44])
        begin
            frac = full[43:21];
            expo = expo - 10'd2;
        end
        else
        begin
            frac = '0;
            expo = '0;
        end
        if (ea == 0 || (eb == 0 && fb[22:21] == 2'b00))
        begin
            res_e = '0;
            res_m = '0;
        end
        else if (expo < DENORM_LIMIT)
        begin
            shift = int'(DENORM_LIMIT - expo);
            shifted = {1'b1, frac} >> shift;
            res_e = '0;
            res_m = (shift >= 24) ? '0 : shifted[22:0];
        end
        else if (expo > INF_LIMIT)
        begin
            res_e = EXP_ALL_ONES;
            res_m = '0;
        end
        else
        begin
            res_e = EXP_W'(expo - EXP_BIAS);
            res_m = frac;
        end
        return {a[31] ^ b[31], res_e, res_m};
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] random_float(int exp_low, int exp_high);
        logic [7:0] e;
        e = 8'($urandom_range(exp_low, exp_high));
        return {1'($urandom), e, 23'($urandom)};
    endfunction

    task automatic send_request(logic [31:0] a, logic [31:0] b, bit with_gaps);
        int gap;
        gap = with_gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_products.push_back(truncated_product(a, b));
        sent_count++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_products.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", product);
            end
            else
            begin
                logic [31:0] want;
                want = expected_products.pop_front();
                checked_count++;
                if (product !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("product mismatch: expected %h actual %h", want, product);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!stall_enable)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 49) == 0)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
            out_stall <= ~out_stall;
        else if (out_stall && $urandom_range(0, 3) == 0)
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] pairs[24][2];
        pairs = '{
            '{32'h3f800000, 32'h3f800000}, '{32'hbfc00000, 32'h3fc00000},
            '{32'h7f7fffff, 32'h7f7fffff}, '{32'h00000000, 32'h3f800000},
            '{32'h00400000, 32'h3f800000}, '{32'h3f800000, 32'h00400000},
            '{32'h3f800000, 32'h00100000}, '{32'h3f800000, 32'h00200000},
            '{32'h3f800000, 32'h00600000}, '{32'h7f800000, 32'h3f800000},
            '{32'h7fffffff, 32'hffffffff}, '{32'h00800000, 32'h00800000},
            '{32'h20000000, 32'h20000000}, '{32'h1f800000, 32'h1f800000},
            '{32'h1fffffff, 32'h20000000}, '{32'h0c000000, 32'h33800000},
            '{32'h3fffffff, 32'h3fffffff}, '{32'h5f800000, 32'h5f800000},
            '{32'h5f000000, 32'h5f7fffff}, '{32'h3f800000, 32'h00400001},
            '{32'h80800000, 32'h807fffff}, '{32'hffffffff, 32'h7f7fffff},
            '{32'h3f800001, 32'h00000000}, '{32'h00800001, 32'h00c00000}
        };
        foreach (pairs[i])
            send_request(pairs[i][0], pairs[i][1], 1'b0);
    endtask

    task automatic test_random_normal(int count);
        repeat (count)
            send_request(random_float(1, 254), random_float(1, 254), 1'b1);
    endtask

    task automatic test_random_edges(int count);
        logic [31:0] a;
        logic [31:0] b;
        repeat (count)
        begin
            case ($urandom_range(0, 4))
                0: begin a = random_float(0, 0); b = random_float(1, 254); end
                1: begin a = random_float(1, 254); b = random_float(0, 0); end
                2: begin a = random_float(20, 110); b = random_float(0, 110); end
                3: begin a = random_float(190, 255); b = random_float(190, 255); end
                default: begin a = $urandom; b = $urandom; end
            endcase
            send_request(a, b, 1'b1);
        end
    endtask

    task automatic test_back_to_back(int count);
        repeat (count)
            send_request($urandom, $urandom, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operand_a = '0;
        operand_b = '0;
        out_stall = 1'b0;
        stall_enable = 1'b0;
        mismatch_count = 0;
        checked_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_for_drain();
        stall_enable = 1'b1;
        test_random_normal(300);
        wait_for_drain();
        test_random_edges(300);
        stall_enable = 1'b0;
        test_back_to_back(100);
        stall_enable = 1'b1;
        test_back_to_back(50);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d requests, checked %0d products", sent_count, checked_count);
        $display("covered zero, denormal, overflow and stall cases; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_products.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ float_multiply_truncating.f @@
+incdir+hdl
hdl/fmt_pkg.sv
hdl/float_multiply_truncating.sv
hdl/fmt_checker.sv
test/tb_float_multiply_truncating.sv
